// ===== hw/rtl/thermistor_b_parameter_to_celsius_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Thermistor unit assertion macros
// Shared property wrappers clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_B_PARAMETER_TO_CELSIUS_UNIT_MACROS_SVH
`define THERMISTOR_B_PARAMETER_TO_CELSIUS_UNIT_MACROS_SVH

// same-cycle implication
`define TBC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Thermistor unit package
// Fixed-point constants, status codes, register indexes and log ROM builder.
// ----------------------------------------------------------------------------
package tbc_pkg;

   localparam int LOG_FRAC = 28;

   localparam logic [23:0] LN2_Q24      = 24'd11629080;
   localparam logic [46:0] INV_ONE      = {7'd100, 40'd0};   // 100 * 2^40
   localparam logic [15:0] KELVIN_CENTI = 16'd27315;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_SAT     = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_SERIES  = 3'd0;
   localparam logic [2:0] CSR_NOMINAL = 3'd1;
   localparam logic [2:0] CSR_BETA    = 3'd2;
   localparam logic [2:0] CSR_T0      = 3'd3;
   localparam logic [2:0] CSR_TRIM    = 3'd4;

   // control bits riding beside the data path
   typedef struct packed {
      logic valid;
      logic bad;    // invalid input or zero register
      logic flag;   // negative log ratio, later non-positive 1/T
   } side_type;

   // log2(1 + idx/2^bits) in Q28 by repeated squaring of a Q31 mantissa
   function automatic logic [28:0] log_rom_raw(input int bits, input int idx);
      logic [63:0] m;
      logic [28:0] acc;
      m   = (64'd1 << 31) + (64'(idx) << (31 - bits));
      acc = '0;
      for (int b = 0; b < LOG_FRAC; b++) begin
         m   = (m * m) >> 31;
         acc = acc << 1;
         if (m[63:32] != 32'd0) begin
            acc[0] = 1'b1;
            m      = m >> 1;
         end
      end
      return acc;
   endfunction

   function automatic logic [28:0] log_rom_entry(input int bits, input int idx);
      logic [28:0] cur;
      logic [28:0] prev;
      if (idx == (1 << bits)) begin
         cur = 29'd1 << LOG_FRAC;
      end else begin
         cur = log_rom_raw(bits, idx);
         if (idx > 0) begin
            prev = log_rom_raw(bits, idx - 1);
            if (cur < prev) begin
               cur = prev;
            end
         end
      end
      return cur;
   endfunction

endpackage

// ===== hw/rtl/tbc_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, NUM_W stages, stalls on enable low.
// ----------------------------------------------------------------------------
module tbc_div #(
   parameter int NUM_W = 59,
   parameter int DEN_W = 26
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] a_num,
   input  logic [DEN_W-1:0] a_den,
   output logic [NUM_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic [DEN_W-1:0] rem_src;
      logic [NUM_W-1:0] num_src;
      logic [NUM_W-1:0] quo_src;
      logic [DEN_W-1:0] den_src;
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      if (g == 0) begin : g_head
         assign rem_src = '0;
         assign num_src = a_num;
         assign quo_src = '0;
         assign den_src = a_den;
      end else begin : g_body
         assign rem_src = rem_ff[g-1];
         assign num_src = num_ff[g-1];
         assign quo_src = quo_ff[g-1];
         assign den_src = den_ff[g-1];
      end

      always_comb begin
         trial  = {rem_src, num_src[NUM_W-1]};
         ge     = (trial >= {1'b0, den_src});
         rem_in = ge ? DEN_W'(trial - {1'b0, den_src}) : trial[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g] <= rem_in;
            num_ff[g] <= num_src << 1;
            quo_ff[g] <= {quo_src[NUM_W-2:0], ge};
            den_ff[g] <= den_src;
         end
      end
   end

   assign quo = quo_ff[NUM_W-1];

endmodule

// ===== hw/rtl/thermistor_b_parameter_to_celsius_unit.sv =====
// A request passes stages A..I, divide 1, stage J, divide 2, stage K and the
// output register on its way to rsp. Throughput: one request per cycle, set by
// the two divider pipelines (59 and 48 stages) and nine front stages all moving together.
// The pipe stalls as a whole only while the output skid stage is full.
// Reset (synchronous, active high) clears all valid bits and loads the
// register defaults 10000, 10000, 3950, 2500, 0.
// ----------------------------------------------------------------------------
// NTC thermistor beta-equation converter
// ADC counts of divider midpoint and supply in, temperature in 0.01 C out.
// ----------------------------------------------------------------------------
`include "thermistor_b_parameter_to_celsius_unit_macros.svh"

module thermistor_b_parameter_to_celsius_unit #(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [14:0] vo_count, [29:15] vcc_count, [31:30] zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] temp_centi
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);

   import tbc_pkg::*;

   localparam int ROM_SIZE = (1 << LOG_TABLE_BITS) + 1;
   localparam int IDX_W    = LOG_TABLE_BITS;
   localparam int FLD_W    = LOG_TABLE_BITS + 16;
   localparam int FRONT    = 9;   // stages A..I
   localparam int DIV1_W   = 59;
   localparam int DIV2_W   = 48;

   // ---------------------------------------------------------------- registers
   logic        [19:0] series_ff;
   logic        [19:0] nominal_ff;
   logic        [13:0] beta_ff;
   logic signed [14:0] t0_ff;
   logic signed [10:0] trim_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff  <= 20'd10000;
         nominal_ff <= 20'd10000;
         beta_ff    <= 14'd3950;
         t0_ff      <= 15'sd2500;
         trim_ff    <= 11'sd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SERIES:  series_ff  <= csr_data;
            CSR_NOMINAL: nominal_ff <= csr_data;
            CSR_BETA:    beta_ff    <= csr_data[13:0];
            CSR_T0:      t0_ff      <= csr_data[14:0];
            CSR_TRIM:    trim_ff    <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow
   // Whole pipe moves on en; the skid stage absorbs the one result that
   // arrives while rsp is stalled, and req_tready drops while it is full.
   logic skid_v_ff;
   logic en;
   assign en         = !skid_v_ff;
   assign req_tready = en;

   // side bits for stages A..I
   side_type sd_ff [FRONT];

   // log2 table
   logic [28:0] rom_w [ROM_SIZE];
   for (genvar gi = 0; gi < ROM_SIZE; gi++) begin : g_rom
      assign rom_w[gi] = log_rom_entry(LOG_TABLE_BITS, gi);
   end

   function automatic logic [5:0] lead_one(input logic [34:0] x);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 35; i++) begin
         if (x[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   // ---------------------------------------------------------------- stage A
   // products: lane 0 = series * vo, lane 1 = (vcc - vo) * nominal
   logic [14:0] vo;
   logic [14:0] vcc;
   logic [14:0] vdiff;
   logic        bad_in;
   logic [34:0] a_x_ff [2];

   assign vo     = req_tdata[14:0];
   assign vcc    = req_tdata[29:15];
   assign vdiff  = vcc - vo;
   assign bad_in = (vo == 15'd0) || (vo >= vcc) || (series_ff == 20'd0) ||
                   (nominal_ff == 20'd0) || (beta_ff == 14'd0);

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff[0] <= 35'(series_ff) * 35'(vo);
         a_x_ff[1] <= 35'(vdiff) * 35'(nominal_ff);
      end
   end

   // ---------------------------------------------------------------- B..F
   logic [34:0]       b_x_ff   [2];
   logic [5:0]        b_p_ff   [2];
   logic [IDX_W-1:0]  c_idx_ff [2];
   logic [15:0]       c_w_ff   [2];
   logic [5:0]        c_p_ff   [2];
   logic [28:0]       d_lo_ff  [2];
   logic [28:0]       d_dif_ff [2];
   logic [15:0]       d_w_ff   [2];
   logic [5:0]        d_p_ff   [2];
   logic [28:0]       e_lo_ff  [2];
   logic [28:0]       e_frac_ff[2];
   logic [5:0]        e_p_ff   [2];
   logic [33:0]       f_log_ff [2];

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [34:0]      sh;
      logic [FLD_W-1:0] fld;
      logic [28:0]      lo;
      logic [28:0]      hi;
      logic [44:0]      prod;

      always_comb begin
         sh   = b_x_ff[ln] << (6'd34 - b_p_ff[ln]);     // leading one to bit 34
         fld  = sh[33 -: FLD_W];
         lo   = rom_w[{1'b0, c_idx_ff[ln]}];
         hi   = rom_w[(IDX_W+1)'(c_idx_ff[ln]) + 1'b1];
         prod = 45'(d_dif_ff[ln]) * 45'(d_w_ff[ln]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            b_x_ff[ln]    <= a_x_ff[ln];
            b_p_ff[ln]    <= lead_one(a_x_ff[ln]);
            c_idx_ff[ln]  <= fld[FLD_W-1 -: IDX_W];
            c_w_ff[ln]    <= fld[15:0];
            c_p_ff[ln]    <= b_p_ff[ln];
            d_lo_ff[ln]   <= lo;
            d_dif_ff[ln]  <= hi - lo;
            d_w_ff[ln]    <= c_w_ff[ln];
            d_p_ff[ln]    <= c_p_ff[ln];
            e_lo_ff[ln]   <= d_lo_ff[ln];
            e_frac_ff[ln] <= prod[44:16];
            e_p_ff[ln]    <= d_p_ff[ln];
            f_log_ff[ln]  <= (34'(e_p_ff[ln]) << LOG_FRAC) + 34'(e_lo_ff[ln]) +
                             34'(e_frac_ff[ln]);
         end
      end
   end

   // ---------------------------------------------------------------- G..I
   logic               g_neg_in;
   logic        [33:0] g_mag_ff;
   logic        [57:0] h_mp_ff;
   logic        [58:0] i_tnum_ff;
   logic        [25:0] i_tden_ff;
   logic        [58:0] i_inum_ff;
   logic        [25:0] i_iden_ff;
   logic signed [16:0] t0c_s;
   logic        [15:0] t0c;

   assign g_neg_in = f_log_ff[1] > f_log_ff[0];
   assign t0c_s    = {{2{t0_ff[14]}}, t0_ff} + 17'sd27315;
   assign t0c      = t0c_s[15:0];   // always positive

   always_ff @(posedge clock) begin
      if (en) begin
         g_mag_ff  <= g_neg_in ? f_log_ff[1] - f_log_ff[0] : f_log_ff[0] - f_log_ff[1];
         h_mp_ff   <= 58'(g_mag_ff) * 58'(LN2_Q24);
         // round half up: (|L| * ln2 + B*2^11) / (B*2^12)
         i_tnum_ff <= 59'(h_mp_ff) + 59'({beta_ff, 11'd0});
         i_tden_ff <= {beta_ff, 12'd0};
         // 1/T0 in Q40
         i_inum_ff <= 59'(INV_ONE) + 59'(t0c >> 1);
         i_iden_ff <= 26'(t0c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FRONT; k++) begin
            sd_ff[k] <= '0;
         end
      end else if (en) begin
         sd_ff[0] <= '{valid: req_tvalid, bad: bad_in, flag: 1'b0};
         for (int k = 1; k < FRONT; k++) begin
            if (k == 6) begin
               // stage G takes the log sign
               sd_ff[k] <= '{valid: sd_ff[k-1].valid, bad: sd_ff[k-1].bad, flag: g_neg_in};
            end else begin
               sd_ff[k] <= sd_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------- divide 1
   logic [DIV1_W-1:0] term_q;
   logic [DIV1_W-1:0] invt0_q;
   side_type          d1_ff [DIV1_W];

   tbc_div #(.NUM_W(DIV1_W), .DEN_W(26)) u_div_term (
      .clock  (clock),
      .enable (en),
      .a_num  (i_tnum_ff),
      .a_den  (i_tden_ff),
      .quo    (term_q)
   );

   tbc_div #(.NUM_W(DIV1_W), .DEN_W(26)) u_div_invt0 (
      .clock  (clock),
      .enable (en),
      .a_num  (i_inum_ff),
      .a_den  (i_iden_ff),
      .quo    (invt0_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV1_W; k++) begin
            d1_ff[k] <= '0;
         end
      end else if (en) begin
         d1_ff[0] <= sd_ff[FRONT-1];
         for (int k = 1; k < DIV1_W; k++) begin
            d1_ff[k] <= d1_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- stage J
   // y = 1/T0 +- ln(R/R0)/B, Q40; fits 45 bits plus sign
   logic signed [48:0] j_y_ff;
   side_type           j_sd_ff;
   logic               j_ypos;
   logic [47:0]        j_num2;
   logic [47:0]        j_den2;
   side_type           j_sd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         j_sd_ff <= '0;
      end else if (en) begin
         j_sd_ff <= d1_ff[DIV1_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         j_y_ff <= d1_ff[DIV1_W-1].flag ?
                   $signed({15'd0, invt0_q[33:0]}) - $signed({2'd0, term_q[46:0]}) :
                   $signed({15'd0, invt0_q[33:0]}) + $signed({2'd0, term_q[46:0]});
      end
   end

   always_comb begin
      j_ypos = !j_y_ff[48] && (j_y_ff != 49'sd0);
      j_num2 = 48'(INV_ONE) + 48'(j_y_ff[47:1]);
      j_den2 = j_ypos ? j_y_ff[47:0] : 48'd1;
      j_sd2  = '{valid: j_sd_ff.valid, bad: j_sd_ff.bad, flag: !j_ypos};
   end

   // ---------------------------------------------------------------- divide 2
   logic [DIV2_W-1:0] tk_q;
   side_type          d2_ff [DIV2_W];

   tbc_div #(.NUM_W(DIV2_W), .DEN_W(DIV2_W)) u_div_temp (
      .clock  (clock),
      .enable (en),
      .a_num  (j_num2),
      .a_den  (j_den2),
      .quo    (tk_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV2_W; k++) begin
            d2_ff[k] <= '0;
         end
      end else if (en) begin
         d2_ff[0] <= j_sd2;
         for (int k = 1; k < DIV2_W; k++) begin
            d2_ff[k] <= d2_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- stage K
   logic signed [49:0] k_t_ff;
   side_type           k_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_sd_ff <= '0;
      end else if (en) begin
         k_sd_ff <= d2_ff[DIV2_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_t_ff <= $signed({2'd0, tk_q}) - $signed({34'd0, KELVIN_CENTI}) +
                   50'(trim_ff);
      end
   end

   // saturate and classify
   logic [15:0] pipe_temp;
   logic [1:0]  pipe_status;

   always_comb begin
      if (k_sd_ff.bad) begin
         pipe_temp   = '0;
         pipe_status = STATUS_INVALID;
      end else if (k_sd_ff.flag || (k_t_ff > 50'sd32767)) begin
         pipe_temp   = 16'h7fff;
         pipe_status = STATUS_SAT;
      end else if (k_t_ff < -50'sd32768) begin
         pipe_temp   = 16'h8000;
         pipe_status = STATUS_SAT;
      end else begin
         pipe_temp   = k_t_ff[15:0];
         pipe_status = STATUS_OK;
      end
   end

   // ---------------------------------------------------------------- output
   logic        rsp_v_ff;
   logic        rsp_v_in;
   logic [15:0] rsp_temp_ff;
   logic [15:0] rsp_temp_in;
   logic [1:0]  rsp_st_ff;
   logic [1:0]  rsp_st_in;
   logic        skid_v_in;
   logic [15:0] skid_temp_ff;
   logic [15:0] skid_temp_in;
   logic [1:0]  skid_st_ff;
   logic [1:0]  skid_st_in;

   always_comb begin
      rsp_v_in     = rsp_v_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_st_in    = rsp_st_ff;
      skid_v_in    = skid_v_ff;
      skid_temp_in = skid_temp_ff;
      skid_st_in   = skid_st_ff;
      if (skid_v_ff) begin
         if (rsp_tready) begin
            rsp_v_in    = 1'b1;
            rsp_temp_in = skid_temp_ff;
            rsp_st_in   = skid_st_ff;
            skid_v_in   = 1'b0;
         end
      end else if (k_sd_ff.valid) begin
         if (rsp_v_ff && !rsp_tready) begin
            skid_v_in    = 1'b1;
            skid_temp_in = pipe_temp;
            skid_st_in   = pipe_status;
         end else begin
            rsp_v_in    = 1'b1;
            rsp_temp_in = pipe_temp;
            rsp_st_in   = pipe_status;
         end
      end else if (rsp_tready) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         rsp_v_ff  <= rsp_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_temp_ff  <= rsp_temp_in;
      rsp_st_ff    <= rsp_st_in;
      skid_temp_ff <= skid_temp_in;
      skid_st_ff   <= skid_st_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_temp_ff;
   assign rsp_tuser  = rsp_st_ff;

   // ---------------------------------------------------------------- checks
   `TBC_ASSERT_IMPLY(a_invalid_zero, rsp_tvalid && rsp_tuser == STATUS_INVALID, rsp_tdata == 16'h0000, "invalid result carries nonzero temperature")
   `TBC_ASSERT_IMPLY(a_sat_rail, rsp_tvalid && rsp_tuser == STATUS_SAT, rsp_tdata == 16'h7fff || rsp_tdata == 16'h8000, "saturated result off the rails")
   `TBC_ASSERT_IMPLY(a_skid_behind_rsp, skid_v_ff, rsp_v_ff, "skid holds data while output is empty")
   `TBC_ASSERT_NEXT(a_skid_catch, rsp_v_ff && !rsp_tready && k_sd_ff.valid && en, skid_v_ff, "result from pipe not caught in skid")

endmodule
